// ----- rtl/core/rmp_pkg.sv -----
// Package for the ReLU max-pool stream block: widths, configuration types,
// register indexes and the small arithmetic helpers shared by the modules.
// No dependencies.
package rmp_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int VAL_W        = 15;
  localparam int MAX_OUT_COLS = 128;
  localparam int SLOT_W       = $clog2(MAX_OUT_COLS);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_ROWS       = 3'd0,
    CFG_IN_COLS       = 3'd1,
    CFG_CHANNEL_COUNT = 3'd2,
    CFG_POOL_ROWS     = 3'd3,
    CFG_POOL_COLS     = 3'd4,
    CFG_OUT_ROWS      = 3'd5,
    CFG_OUT_COLS      = 3'd6
  } cfg_idx_t;

  // Configuration after clamping to the legal ranges.
  typedef struct packed {
    logic [8:0] ir;
    logic [8:0] ic;
    logic [6:0] cc;
    logic [3:0] pr;
    logic [3:0] pc;
    logic [7:0] orows;
    logic [7:0] ocols;
  } cfg_t;

  // Decoded raster position of one sample.
  typedef struct packed {
    logic              in_area;
    logic              first_col;
    logic              last_col;
    logic              first_row;
    logic              last_row;
    logic [SLOT_W-1:0] slot;
    logic [5:0]        chan;
    logic [6:0]        row;
    logic [6:0]        col;
    logic              frame_last;
  } dec_t;

  typedef struct packed {
    logic item_valid;
    logic fwd_hit;
  } stat_t;

  typedef struct packed {
    logic [7:0] q;
    logic [3:0] r;
  } divmod_t;

  function automatic logic [8:0] clamp_cfg(logic [8:0] v, logic [8:0] hi);
    logic [8:0] res;
    if (v == 9'd0) begin
      res = 9'd1;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Quotient and remainder of an 8-bit count by a divisor of 1 to 8. Powers of
  // two are shifts; the other divisors use an exact reciprocal multiplication.
  function automatic divmod_t divmod8(logic [7:0] n, logic [3:0] d);
    logic [18:0] prod;
    logic [11:0] rem;
    divmod_t     res;
    prod = '0;
    res  = '0;
    case (d)
      4'd1: res.q = n;
      4'd2: res.q = {1'b0, n[7:1]};
      4'd3: begin
        prod  = {11'd0, n} * 19'd171;
        res.q = prod[16:9];
      end
      4'd4: res.q = {2'b00, n[7:2]};
      4'd5: begin
        prod  = {11'd0, n} * 19'd205;
        res.q = prod[17:10];
      end
      4'd6: begin
        prod  = {11'd0, n} * 19'd171;
        res.q = {1'b0, prod[16:10]};
      end
      4'd7: begin
        prod  = {11'd0, n} * 19'd293;
        res.q = prod[18:11];
      end
      4'd8: res.q = {3'b000, n[7:3]};
      default: res.q = n;
    endcase
    rem   = {4'd0, n} - {4'd0, res.q} * {8'd0, d};
    res.r = rem[3:0];
    return res;
  endfunction

endpackage

// ----- rtl/core/relu_max_pool_stream.sv -----
// Top level of the fused ReLU and max-pool stream block.
// Holds the configuration registers; depends on rmp_pkg, rmp_position and rmp_pool.
//
// Samples enter on the in_ channel in channel, row, column raster order, one
// signed Q8.8 word per accepted handshake (in_valid high, in_stall low).
// For each non-overlapping pool window the block sends one word on the out_
// channel: the maximum of zero and the window samples, tagged with channel,
// pooled row and pooled column, with out_frame_last on the final window.
// Samples outside the pooled area advance the position but give no word.
// Throughput is one sample per clock while in_stall is low. A sample that
// closes a window passes through the input register, which lines up the
// registered line store read, and then through the result register.
// Configuration is written on the cfg_ channel, which is always ready, and
// must only be changed while the stream is idle.
// Reset clears the position counters and the pipeline; the line store is
// left as it is and is written before it is read. When the receiver stalls,
// the result register holds its word, samples that close no window keep
// flowing, and in_stall rises while a sample that closes a window waits in
// the input register behind the held word.
module relu_max_pool_stream
  import rmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VAL_W-1:0]      out_pooled_value,
  output logic [5:0]            out_channel,
  output logic [6:0]            out_row,
  output logic [6:0]            out_col,
  output logic                  out_frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [8:0] in_rows_r;
  logic [8:0] in_cols_r;
  logic [6:0] channel_count_r;
  logic [3:0] pool_rows_r;
  logic [3:0] pool_cols_r;
  logic [7:0] out_rows_r;
  logic [7:0] out_cols_r;
  logic [8:0] ocols_c;
  cfg_t       cfg_c;
  dec_t       dec;
  stat_t      stat;
  logic       acc;

  assign cfg_ready = 1'b1;
  assign acc       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_rows_r       <= 9'd12;
      in_cols_r       <= 9'd12;
      channel_count_r <= 7'd6;
      pool_rows_r     <= 4'd2;
      pool_cols_r     <= 4'd2;
      out_rows_r      <= 8'd6;
      out_cols_r      <= 8'd6;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IN_ROWS:       in_rows_r       <= cfg_data;
        CFG_IN_COLS:       in_cols_r       <= cfg_data;
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_data[6:0];
        CFG_POOL_ROWS:     pool_rows_r     <= cfg_data[3:0];
        CFG_POOL_COLS:     pool_cols_r     <= cfg_data[3:0];
        CFG_OUT_ROWS:      out_rows_r      <= cfg_data[7:0];
        CFG_OUT_COLS:      out_cols_r      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ocols_c = clamp_cfg({1'b0, out_cols_r}, 9'd128);
    if (ocols_c > 9'(MAX_OUT_COLS)) begin
      ocols_c = 9'(MAX_OUT_COLS);
    end
    cfg_c.ir    = clamp_cfg(in_rows_r, 9'd256);
    cfg_c.ic    = clamp_cfg(in_cols_r, 9'd256);
    cfg_c.cc    = 7'(clamp_cfg({2'd0, channel_count_r}, 9'd64));
    cfg_c.pr    = 4'(clamp_cfg({5'd0, pool_rows_r}, 9'd8));
    cfg_c.pc    = 4'(clamp_cfg({5'd0, pool_cols_r}, 9'd8));
    cfg_c.orows = 8'(clamp_cfg({1'b0, out_rows_r}, 9'd128));
    cfg_c.ocols = ocols_c[7:0];
  end

  rmp_position u_position (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_c),
    .acc   (acc),
    .dec   (dec)
  );

  rmp_pool u_pool (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .dec       (dec),
    .sample    (in_sample),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_pooled_value),
    .out_chan  (out_channel),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_last  (out_frame_last),
    .stat      (stat)
  );

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stat.item_valid)
    else $error("input stalled with no word held in the input register");

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fwd_hit |-> stat.item_valid)
    else $error("line store bypass set without a held word");

  a_last_is_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_last) |->
      ({1'b0, out_col} == cfg_c.ocols - 8'd1) && ({1'b0, out_row} == cfg_c.orows - 8'd1))
    else $error("frame end flagged away from the last pooled position");

endmodule

// ----- rtl/core/rmp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rmp_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/rmp_position.sv -----
// Raster position counters and window decode for the ReLU max-pool stream.
// Depends on rmp_pkg.
module rmp_position
  import rmp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic acc,
  output dec_t dec
);

  logic [7:0]  col_pos_r, col_pos_nxt;
  logic [7:0]  row_pos_r, row_pos_nxt;
  logic [5:0]  chan_pos_r, chan_pos_nxt;
  logic [11:0] row_lim;
  logic [11:0] col_lim;
  divmod_t     cdm;
  divmod_t     rdm;

  always_comb begin
    row_lim = {4'd0, cfg.orows} * {8'd0, cfg.pr};
    col_lim = {4'd0, cfg.ocols} * {8'd0, cfg.pc};
    cdm     = divmod8(col_pos_r, cfg.pc);
    rdm     = divmod8(row_pos_r, cfg.pr);

    dec.in_area    = ({4'd0, row_pos_r} < row_lim) && ({4'd0, col_pos_r} < col_lim);
    dec.first_col  = (cdm.r == 4'd0);
    dec.last_col   = (cdm.r == cfg.pc - 4'd1);
    dec.first_row  = (rdm.r == 4'd0);
    dec.last_row   = (rdm.r == cfg.pr - 4'd1);
    dec.slot       = cdm.q[SLOT_W-1:0];
    dec.chan       = chan_pos_r;
    dec.row        = rdm.q[6:0];
    dec.col        = cdm.q[6:0];
    dec.frame_last = ({1'b0, chan_pos_r} == cfg.cc - 7'd1)
                     && (rdm.q == cfg.orows - 8'd1)
                     && (cdm.q == cfg.ocols - 8'd1);
  end

  always_comb begin
    col_pos_nxt  = col_pos_r;
    row_pos_nxt  = row_pos_r;
    chan_pos_nxt = chan_pos_r;
    if (acc) begin
      if ({1'b0, col_pos_r} + 9'd1 >= cfg.ic) begin
        col_pos_nxt = 8'd0;
        if ({1'b0, row_pos_r} + 9'd1 >= cfg.ir) begin
          row_pos_nxt = 8'd0;
          if ({1'b0, chan_pos_r} + 7'd1 >= cfg.cc) begin
            chan_pos_nxt = 6'd0;
          end else begin
            chan_pos_nxt = chan_pos_r + 6'd1;
          end
        end else begin
          row_pos_nxt = row_pos_r + 8'd1;
        end
      end else begin
        col_pos_nxt = col_pos_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r  <= 8'd0;
      row_pos_r  <= 8'd0;
      chan_pos_r <= 6'd0;
    end else begin
      col_pos_r  <= col_pos_nxt;
      row_pos_r  <= row_pos_nxt;
      chan_pos_r <= chan_pos_nxt;
    end
  end

endmodule

// ----- rtl/core/rmp_pool.sv -----
// Input register, window and band maximum logic, line store and result register.
// Depends on rmp_pkg and rmp_ram.
module rmp_pool
  import rmp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  dec_t                dec,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VAL_W-1:0]    out_value,
  output logic [5:0]          out_chan,
  output logic [6:0]          out_row,
  output logic [6:0]          out_col,
  output logic                out_last,
  output stat_t               stat
);

  logic               item_valid_r;
  dec_t               item_dec_r;
  logic [VAL_W-1:0]   item_val_r;
  logic [VAL_W-1:0]   wcm_r, wcm_nxt;
  logic               fwd_hit_r;
  logic [VAL_W-1:0]   fwd_data_r;
  logic               out_valid_r;
  logic [VAL_W-1:0]   out_value_r;
  logic [5:0]         out_chan_r;
  logic [6:0]         out_row_r;
  logic [6:0]         out_col_r;
  logic               out_last_r;
  logic [VAL_W-1:0]   ram_rd;
  logic [VAL_W-1:0]   stored;
  logic [VAL_W-1:0]   band;
  logic               emit;
  logic               adv;
  logic               wr_en;

  rmp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_OUT_COLS)
  ) u_band_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (item_dec_r.slot),
    .wr_data (band),
    .rd_en   (acc),
    .rd_addr (dec.slot),
    .rd_data (ram_rd)
  );

  always_comb begin
    if (item_dec_r.first_col || item_val_r > wcm_r) begin
      wcm_nxt = item_val_r;
    end else begin
      wcm_nxt = wcm_r;
    end
    stored = fwd_hit_r ? fwd_data_r : ram_rd;
    if (!item_dec_r.first_row && stored > wcm_nxt) begin
      band = stored;
    end else begin
      band = wcm_nxt;
    end
    emit     = item_dec_r.in_area && item_dec_r.last_col && item_dec_r.last_row;
    adv      = item_valid_r && (!emit || !out_valid_r || !out_stall);
    wr_en    = adv && item_dec_r.in_area && item_dec_r.last_col;
    in_stall = item_valid_r && !adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      wcm_r        <= '0;
      fwd_hit_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (acc) begin
        item_valid_r <= 1'b1;
        fwd_hit_r    <= wr_en && (item_dec_r.slot == dec.slot);
      end else if (adv) begin
        item_valid_r <= 1'b0;
        fwd_hit_r    <= 1'b0;
      end
      if (adv && item_dec_r.in_area) begin
        wcm_r <= wcm_nxt;
      end
      if (adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      item_dec_r <= dec;
      item_val_r <= sample[SAMPLE_W-1] ? '0 : sample[VAL_W-1:0];
      fwd_data_r <= band;
    end
    if (adv && emit) begin
      out_value_r <= band;
      out_chan_r  <= item_dec_r.chan;
      out_row_r   <= item_dec_r.row;
      out_col_r   <= item_dec_r.col;
      out_last_r  <= item_dec_r.frame_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_chan        = out_chan_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_last        = out_last_r;
  assign stat.item_valid = item_valid_r;
  assign stat.fwd_hit    = fwd_hit_r;

endmodule
